/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsp assertion failed");

// next-cycle implication, checked outside reset
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsp assertion failed");

`endif

/* hw/rtl/fsp_pkg.sv */
// types and constants of the format specifier parser
package fsp_pkg;

    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 16;
    localparam int MOD_W   = 3;
    localparam int PHASE_W = 3;
    localparam int FLAG_W  = 5;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_FLAGS = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WIDTH = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PREC  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_H1    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_L1    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RUN   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_LAST  = 3'd6;

    // length modifier codes
    localparam logic [MOD_W-1:0] MOD_NONE = 3'd0;
    localparam logic [MOD_W-1:0] MOD_H    = 3'd1;
    localparam logic [MOD_W-1:0] MOD_HH   = 3'd2;
    localparam logic [MOD_W-1:0] MOD_L    = 3'd3;
    localparam logic [MOD_W-1:0] MOD_LL   = 3'd4;
    localparam logic [MOD_W-1:0] MOD_J    = 3'd5;
    localparam logic [MOD_W-1:0] MOD_Z    = 3'd6;

    // flag bit positions
    localparam int FLAG_MINUS = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_HASH  = 2;
    localparam int FLAG_ZERO  = 3;
    localparam int FLAG_SPACE = 4;

    // characters
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
    localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_J     = 8'h6A;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h7A;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [FLAG_W-1:0]  flags;
        logic               prec_seen;
        logic [MOD_W-1:0]   mod_code;
        logic               sat;
    } t_ctl;

    localparam t_ctl CTL_CLEAR = '{
        phase:     PH_FLAGS,
        flags:     '0,
        prec_seen: 1'b0,
        mod_code:  MOD_NONE,
        sat:       1'b0
    };

endpackage

/* hw/rtl/fsp_if.sv */
// channel interfaces: characters in, parsed specifiers out
interface fsp_char_if import fsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface fsp_spec_if import fsp_pkg::*;;
    logic               valid;
    logic               ready;
    logic               left_align;
    logic               force_sign;
    logic               alt_form;
    logic               zero_pad;
    logic               space_sign;
    logic [FIELD_W-1:0] field_width;
    logic               has_precision;
    logic [FIELD_W-1:0] prec_value;
    logic [MOD_W-1:0]   length_mod;
    logic [CHAR_W-1:0]  conversion;
    logic               saturated;

    modport source (
        output valid, input ready,
        output left_align, output force_sign, output alt_form, output zero_pad,
        output space_sign, output field_width, output has_precision,
        output prec_value, output length_mod, output conversion, output saturated
    );
    modport sink (
        input valid, output ready,
        input left_align, input force_sign, input alt_form, input zero_pad,
        input space_sign, input field_width, input has_precision,
        input prec_value, input length_mod, input conversion, input saturated
    );
endinterface

/* hw/rtl/format_spec_parser.sv */
// format specifier parser: characters after a percent sign in, one parsed specifier out
//
// i_char carries one character per transfer; start_req marks the first character
// after the percent sign and clears every parsed field before that character.
// o_spec carries one parsed specifier per transfer, issued for the character that
// ends the specifier (the conversion); all other characters give no transfer.
// After a specifier is issued the parser is back in its initial state, so the
// next character starts a new specifier with or without start_req.
// A character taken sits in the input register and is parsed from there into the
// result register if it ends a specifier. Throughput: one character per cycle when
// not stalled, set by the single times-ten accumulator step between the
// input and result register. Width and precision count up to 2^COUNT_BITS-1,
// stick there and raise saturated; the output fields carry their low 16 bits.
// Reset (synchronous, active low) empties both register stages and returns the
// parser to the flags phase. While o_spec is stalled, characters that end no
// specifier keep flowing; a character that ends one waits in the input register,
// and i_char.ready drops until the held result is taken.
module format_spec_parser import fsp_pkg::*; #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsp_char_if.sink   i_char,
    fsp_spec_if.source o_spec
);

    // input register
    logic                  r_in_valid;
    logic [CHAR_W-1:0]     r_ch;
    logic                  r_start;

    // parser state
    t_ctl                  r_ctl;
    logic [COUNT_BITS-1:0] r_width;
    logic [COUNT_BITS-1:0] r_prec;

    // result register
    logic                  r_out_valid;
    t_ctl                  r_out_ctl;
    logic [FIELD_W-1:0]    r_out_width;
    logic [FIELD_W-1:0]    r_out_prec;
    logic [CHAR_W-1:0]     r_out_conv;

    t_ctl                  step_ctl;
    logic [COUNT_BITS-1:0] step_width;
    logic [COUNT_BITS-1:0] step_prec;
    logic                  step_emit;
    logic                  out_free;
    logic                  proc;
    logic                  in_take;

    fsp_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .i_ctl   (r_ctl),
        .i_width (r_width),
        .i_prec  (r_prec),
        .i_ch    (r_ch),
        .i_start (r_start),
        .o_ctl   (step_ctl),
        .o_width (step_width),
        .o_prec  (step_prec),
        .o_emit  (step_emit)
    );

    assign out_free     = !r_out_valid || o_spec.ready;
    // a character that ends no specifier never needs the result register
    assign proc         = r_in_valid && (!step_emit || out_free);
    assign i_char.ready = !r_in_valid || proc;
    assign in_take      = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch    <= i_char.ch;
            r_start <= i_char.start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= CTL_CLEAR;
            r_width <= '0;
            r_prec  <= '0;
        end else if (proc) begin
            if (step_emit) begin
                r_ctl   <= CTL_CLEAR;
                r_width <= '0;
                r_prec  <= '0;
            end else begin
                r_ctl   <= step_ctl;
                r_width <= step_width;
                r_prec  <= step_prec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_spec.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && step_emit) begin
            r_out_ctl   <= step_ctl;
            r_out_width <= FIELD_W'(step_width);
            r_out_prec  <= FIELD_W'(step_prec);
            r_out_conv  <= r_ch;
        end
    end

    assign o_spec.valid         = r_out_valid;
    assign o_spec.left_align    = r_out_ctl.flags[FLAG_MINUS];
    assign o_spec.force_sign    = r_out_ctl.flags[FLAG_PLUS];
    assign o_spec.alt_form      = r_out_ctl.flags[FLAG_HASH];
    assign o_spec.zero_pad      = r_out_ctl.flags[FLAG_ZERO];
    assign o_spec.space_sign    = r_out_ctl.flags[FLAG_SPACE];
    assign o_spec.field_width   = r_out_width;
    assign o_spec.has_precision = r_out_ctl.prec_seen;
    assign o_spec.prec_value    = r_out_prec;
    assign o_spec.length_mod    = r_out_ctl.mod_code;
    assign o_spec.conversion    = r_out_conv;
    assign o_spec.saturated     = r_out_ctl.sat;

endmodule

/* hw/rtl/fsp_step.sv */
// next-state logic of the parser for one character
module fsp_step import fsp_pkg::*; #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  t_ctl                  i_ctl,
    input  logic [COUNT_BITS-1:0] i_width,
    input  logic [COUNT_BITS-1:0] i_prec,
    input  logic [CHAR_W-1:0]     i_ch,
    input  logic                  i_start,
    output t_ctl                  o_ctl,
    output logic [COUNT_BITS-1:0] o_width,
    output logic [COUNT_BITS-1:0] o_prec,
    output logic                  o_emit
);

    localparam int MAC_W = COUNT_BITS + 4;

    t_ctl                  base;
    logic [COUNT_BITS-1:0] base_width;
    logic [COUNT_BITS-1:0] base_prec;
    logic                  is_dig;
    logic [3:0]            digit;
    logic [MAC_W-1:0]      acc_x;
    logic [MAC_W-1:0]      mac_sum;
    logic                  ovf;
    logic [COUNT_BITS-1:0] mac_val;
    logic [PHASE_W-1:0]    me_phase;
    logic [MOD_W-1:0]      me_mod;
    logic                  me_emit;

    always_comb begin
        base       = i_start ? CTL_CLEAR : i_ctl;
        base_width = i_start ? '0 : i_width;
        base_prec  = i_start ? '0 : i_prec;
    end

    // one shared times-ten-plus-digit unit, width and precision never grow together
    always_comb begin
        is_dig  = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        digit   = 4'(i_ch - CH_ZERO);
        acc_x   = MAC_W'((base.phase == PH_PREC) ? base_prec : base_width);
        mac_sum = (acc_x << 3) + (acc_x << 1) + MAC_W'(digit);
        ovf     = |mac_sum[MAC_W-1:COUNT_BITS];
        mac_val = ovf ? '1 : mac_sum[COUNT_BITS-1:0];
    end

    // modifier letter or end of specifier
    always_comb begin
        me_phase = base.phase;
        me_mod   = base.mod_code;
        me_emit  = 1'b0;
        if (i_ch == CH_H) begin
            me_phase = PH_H1;
        end else if (i_ch == CH_L) begin
            me_phase = PH_L1;
        end else if (i_ch == CH_J) begin
            me_phase = PH_LAST;
            me_mod   = MOD_J;
        end else if (i_ch == CH_Z) begin
            me_phase = PH_LAST;
            me_mod   = MOD_Z;
        end else begin
            me_emit = 1'b1;
        end
    end

    always_comb begin
        o_ctl   = base;
        o_width = base_width;
        o_prec  = base_prec;
        o_emit  = 1'b0;
        case (base.phase)
            PH_WIDTH: begin
                if (is_dig) begin
                    o_width   = mac_val;
                    o_ctl.sat = base.sat | ovf;
                end else if (i_ch == CH_DOT) begin
                    o_ctl.prec_seen = 1'b1;
                    o_ctl.phase     = PH_PREC;
                end else begin
                    o_ctl.phase    = me_phase;
                    o_ctl.mod_code = me_mod;
                    o_emit         = me_emit;
                end
            end
            PH_PREC: begin
                if (is_dig) begin
                    o_prec    = mac_val;
                    o_ctl.sat = base.sat | ovf;
                end else begin
                    o_ctl.phase    = me_phase;
                    o_ctl.mod_code = me_mod;
                    o_emit         = me_emit;
                end
            end
            PH_H1: begin
                if (i_ch == CH_H) begin
                    o_ctl.mod_code = MOD_HH;
                    o_ctl.phase    = PH_RUN;
                end else begin
                    o_ctl.mod_code = MOD_H;
                    o_emit         = 1'b1;
                end
            end
            PH_L1: begin
                if (i_ch == CH_L) begin
                    o_ctl.mod_code = MOD_LL;
                    o_ctl.phase    = PH_RUN;
                end else begin
                    o_ctl.mod_code = MOD_L;
                    o_emit         = 1'b1;
                end
            end
            PH_RUN: begin
                o_emit = !((i_ch == CH_H) || (i_ch == CH_L));
            end
            PH_LAST: begin
                o_emit = 1'b1;
            end
            default: begin
                // flags phase, a zero here is the zero flag and not a digit
                if (i_ch == CH_MINUS) begin
                    o_ctl.flags[FLAG_MINUS] = 1'b1;
                end else if (i_ch == CH_PLUS) begin
                    o_ctl.flags[FLAG_PLUS] = 1'b1;
                end else if (i_ch == CH_HASH) begin
                    o_ctl.flags[FLAG_HASH] = 1'b1;
                end else if (i_ch == CH_ZERO) begin
                    o_ctl.flags[FLAG_ZERO] = 1'b1;
                end else if (i_ch == CH_SPACE) begin
                    o_ctl.flags[FLAG_SPACE] = 1'b1;
                end else if (is_dig) begin
                    o_width     = mac_val;
                    o_ctl.sat   = base.sat | ovf;
                    o_ctl.phase = PH_WIDTH;
                end else if (i_ch == CH_DOT) begin
                    o_ctl.prec_seen = 1'b1;
                    o_ctl.phase     = PH_PREC;
                end else begin
                    o_ctl.phase    = me_phase;
                    o_ctl.mod_code = me_mod;
                    o_emit         = me_emit;
                end
            end
        endcase
    end

endmodule

/* hw/rtl/fsp_checker.sv */
// port-level checks of the format specifier parser, bound to the top level
`include "assert_macros.svh"

module fsp_checker import fsp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_has_precision,
    input logic [FIELD_W-1:0] i_prec_value,
    input logic [MOD_W-1:0]   i_length_mod,
    input logic [CHAR_W-1:0]  i_conversion
);

    logic stalled;
    logic no_dot;
    logic mod_ok;

    assign stalled = i_out_valid && !i_out_ready;
    assign no_dot  = i_out_valid && !i_has_precision;
    assign mod_ok  = (i_length_mod == MOD_NONE) || (i_length_mod == MOD_H) ||
                     (i_length_mod == MOD_HH) || (i_length_mod == MOD_L) ||
                     (i_length_mod == MOD_LL) || (i_length_mod == MOD_J) ||
                     (i_length_mod == MOD_Z);

    `FSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, i_out_valid)

    `FSP_ASSERT_NEXT(a_conv_stable, i_clk, i_rst_n, stalled, $stable(i_conversion))

    `FSP_ASSERT_NEXT(a_mod_stable, i_clk, i_rst_n, stalled, $stable(i_length_mod))

    // precision digits only accumulate after a dot
    `FSP_ASSERT_NOW(a_prec_needs_dot, i_clk, i_rst_n, no_dot, i_prec_value == '0)

    `FSP_ASSERT_NOW(a_mod_code_range, i_clk, i_rst_n, i_out_valid, mod_ok)

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_spec.valid),
    .i_out_ready     (o_spec.ready),
    .i_has_precision (o_spec.has_precision),
    .i_prec_value    (o_spec.prec_value),
    .i_length_mod    (o_spec.length_mod),
    .i_conversion    (o_spec.conversion)
);

/* test/tb_format_spec_parser.sv */
`timescale 1ns / 1ps
// testbench of the format specifier parser: character stream in, parsed specifiers checked
module tb_format_spec_parser;
    import fsp_pkg::*;

    localparam int COUNT_BITS = 16;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic               left_align;
        logic               force_sign;
        logic               alt_form;
        logic               zero_pad;
        logic               space_sign;
        logic [FIELD_W-1:0] field_width;
        logic               has_precision;
        logic [FIELD_W-1:0] prec_value;
        logic [MOD_W-1:0]   length_mod;
        logic [CHAR_W-1:0]  conversion;
        logic               saturated;
    } t_spec;

    logic i_clk;
    logic i_rst_n;

    fsp_char_if chars_in ();
    fsp_spec_if specs_out ();

    format_spec_parser #(.COUNT_BITS(COUNT_BITS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chars_in),
        .o_spec  (specs_out)
    );

    // parser state as the specifier stream is predicted
    logic [PHASE_W-1:0]    ps_phase;
    logic [FLAG_W-1:0]     ps_flags;
    logic [COUNT_BITS-1:0] ps_width;
    logic [COUNT_BITS-1:0] ps_prec;
    logic                  ps_dot;
    logic [MOD_W-1:0]      ps_mod;
    logic                  ps_sat;

    t_spec expected_specs[$];
    int    n_chars;
    int    n_errors;
    bit    idle_on;
    int    hold_cycles;
    int    stall_left;

    logic [CHAR_W-1:0] flag_chars [5] = '{CH_MINUS, CH_PLUS, CH_HASH, CH_ZERO, CH_SPACE};
    string conv_chars = "diouxXcspfeEgGaAn%";

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_format_spec_parser: FAIL");
        $finish;
    end

    function automatic void clear_parse();
        ps_phase = PH_FLAGS;
        ps_flags = '0;
        ps_width = '0;
        ps_prec  = '0;
        ps_dot   = 1'b0;
        ps_mod   = MOD_NONE;
        ps_sat   = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // times-ten step, sticking at the counter maximum
    function automatic logic [COUNT_BITS-1:0] acc_digit(input logic [COUNT_BITS-1:0] acc,
                                                        input logic [CHAR_W-1:0] c);
        longint unsigned v;
        v = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
        if (v > COUNT_MAX) begin
            ps_sat = 1'b1;
            return COUNT_BITS'(COUNT_MAX);
        end
        return COUNT_BITS'(v);
    endfunction

    function automatic t_spec take_spec(input logic [CHAR_W-1:0] c);
        t_spec r;
        r.left_align    = ps_flags[FLAG_MINUS];
        r.force_sign    = ps_flags[FLAG_PLUS];
        r.alt_form      = ps_flags[FLAG_HASH];
        r.zero_pad      = ps_flags[FLAG_ZERO];
        r.space_sign    = ps_flags[FLAG_SPACE];
        r.field_width   = ps_width[FIELD_W-1:0];
        r.has_precision = ps_dot;
        r.prec_value    = ps_prec[FIELD_W-1:0];
        r.length_mod    = ps_mod;
        r.conversion    = c;
        r.saturated     = ps_sat;
        clear_parse();
        return r;
    endfunction

    // a character that is no flag, digit or dot here: a modifier or the conversion
    function automatic bit mod_or_end(input logic [CHAR_W-1:0] c, output t_spec r);
        r = '0;
        if (c == CH_H) begin
            ps_phase = PH_H1;
        end else if (c == CH_L) begin
            ps_phase = PH_L1;
        end else if (c == CH_J) begin
            ps_mod = MOD_J;
            ps_phase = PH_LAST;
        end else if (c == CH_Z) begin
            ps_mod = MOD_Z;
            ps_phase = PH_LAST;
        end else begin
            r = take_spec(c);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic start,
                                      output t_spec r);
        bit done;
        done = 1'b0;
        r = '0;
        if (start)
            clear_parse();
        case (ps_phase)
            PH_WIDTH: begin
                if (is_digit(c))
                    ps_width = acc_digit(ps_width, c);
                else if (c == CH_DOT) begin
                    ps_dot = 1'b1;
                    ps_phase = PH_PREC;
                end else
                    done = mod_or_end(c, r);
            end
            PH_PREC: begin
                if (is_digit(c))
                    ps_prec = acc_digit(ps_prec, c);
                else
                    done = mod_or_end(c, r);
            end
            PH_H1: begin
                if (c == CH_H) begin
                    ps_mod = MOD_HH;
                    ps_phase = PH_RUN;
                end else begin
                    ps_mod = MOD_H;
                    r = take_spec(c);
                    done = 1'b1;
                end
            end
            PH_L1: begin
                if (c == CH_L) begin
                    ps_mod = MOD_LL;
                    ps_phase = PH_RUN;
                end else begin
                    ps_mod = MOD_L;
                    r = take_spec(c);
                    done = 1'b1;
                end
            end
            PH_RUN: begin
                if (c != CH_H && c != CH_L) begin
                    r = take_spec(c);
                    done = 1'b1;
                end
            end
            PH_LAST: begin
                r = take_spec(c);
                done = 1'b1;
            end
            default: begin
                if (c == CH_MINUS)
                    ps_flags[FLAG_MINUS] = 1'b1;
                else if (c == CH_PLUS)
                    ps_flags[FLAG_PLUS] = 1'b1;
                else if (c == CH_HASH)
                    ps_flags[FLAG_HASH] = 1'b1;
                else if (c == CH_ZERO)
                    ps_flags[FLAG_ZERO] = 1'b1;
                else if (c == CH_SPACE)
                    ps_flags[FLAG_SPACE] = 1'b1;
                else if (is_digit(c)) begin
                    ps_width = acc_digit(ps_width, c);
                    ps_phase = PH_WIDTH;
                end else if (c == CH_DOT) begin
                    ps_dot = 1'b1;
                    ps_phase = PH_PREC;
                end else
                    done = mod_or_end(c, r);
            end
        endcase
        return done;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic start);
        t_spec r;
        if (idle_on && $urandom_range(0, 6) == 0) begin
            chars_in.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        chars_in.valid     <= 1'b1;
        chars_in.ch        <= c;
        chars_in.start_req <= start;
        @(posedge i_clk);
        while (!chars_in.ready) @(posedge i_clk);
        n_chars++;
        if (parse_char(c, start, r))
            expected_specs.push_back(r);
    endtask

    task automatic send_seq(input logic [CHAR_W-1:0] seq[$], input bit start);
        foreach (seq[i])
            send_char(seq[i], start && i == 0);
    endtask

    task automatic wait_all_specs();
        chars_in.valid <= 1'b0;
        while (expected_specs.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_digit(input bit nonzero);
        return CH_ZERO + CHAR_W'($urandom_range(nonzero ? 1 : 0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_conv();
        if ($urandom_range(0, 3) == 0)
            return CHAR_W'($urandom_range(0, 255));
        return conv_chars[$urandom_range(0, conv_chars.len() - 1)];
    endfunction

    // specifier with random content, its conversion sometimes a raw byte; long digit runs now and then
    task automatic send_random_spec();
        logic [CHAR_W-1:0] seq[$];
        int n;
        seq = {};
        repeat ($urandom_range(0, 3)) seq.push_back(flag_chars[$urandom_range(0, 4)]);
        n = $urandom_range(0, 9);
        if (n >= 4) begin
            seq.push_back(rand_digit(1'b1));
            repeat (n == 9 ? $urandom_range(4, 6) : $urandom_range(0, 2))
                seq.push_back(rand_digit(1'b0));
        end
        if ($urandom_range(0, 9) < 4) begin
            seq.push_back(CH_DOT);
            n = $urandom_range(0, 9);
            repeat (n == 9 ? $urandom_range(5, 7) : $urandom_range(0, 3))
                seq.push_back(rand_digit(1'b0));
        end
        case ($urandom_range(0, 9))
            3: seq.push_back(CH_H);
            4: begin
                seq.push_back(CH_H);
                seq.push_back(CH_H);
                repeat ($urandom_range(0, 2)) seq.push_back($urandom_range(0, 1) ? CH_H : CH_L);
            end
            5: seq.push_back(CH_L);
            6: begin
                seq.push_back(CH_L);
                seq.push_back(CH_L);
                repeat ($urandom_range(0, 2)) seq.push_back($urandom_range(0, 1) ? CH_H : CH_L);
            end
            7: seq.push_back(CH_J);
            8: seq.push_back(CH_Z);
            default: ;
        endcase
        seq.push_back(rand_conv());
        send_seq(seq, $urandom_range(0, 3) != 0);
    endtask

    task automatic test_flags_and_fields();
        // every flag, width, precision and an hh run that swallows an l
        send_seq('{CH_MINUS, CH_PLUS, CH_HASH, CH_ZERO, CH_SPACE, CH_ZERO + 8'd1, CH_DOT,
                   CH_ZERO + 8'd2, CH_H, CH_H, CH_L, 8'h64}, 1'b1);
    endtask

    task automatic test_special_cases();
        // zero flag then width 50, flag after width ends the specifier
        send_seq('{CH_ZERO, CH_ZERO + 8'd5, CH_ZERO, CH_MINUS}, 1'b0);
        // single l followed by h: h is the conversion
        send_seq('{CH_L, CH_H}, 1'b0);
        // after j anything is the conversion, even a zero byte
        send_seq('{CH_J, 8'h00}, 1'b1);
        // second dot
        send_seq('{CH_DOT, CH_DOT}, 1'b0);
    endtask

    task automatic test_saturation();
        send_seq('{CH_ZERO + 8'd7, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, 8'hFF}, 1'b1);
    endtask

    task automatic test_random_stream(input int upto);
        while (n_chars < upto) begin
            if ($urandom_range(0, 6) == 0) begin
                // noise: raw bytes, sometimes restarting mid-specifier
                repeat ($urandom_range(1, 4))
                    send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else
                send_random_spec();
        end
    endtask

    task automatic test_output_hold();
        hold_cycles = 300;
        repeat (24) send_char(conv_chars[$urandom_range(0, conv_chars.len() - 1)], 1'b1);
        wait_all_specs();
    endtask

    // result ready: random stall bursts and the long hold-off
    initial begin
        specs_out.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                specs_out.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left != 0) begin
                specs_out.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                specs_out.ready <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else
                specs_out.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_spec got;
        t_spec want;
        if (i_rst_n && specs_out.valid && specs_out.ready) begin
            got = '{specs_out.left_align, specs_out.force_sign, specs_out.alt_form,
                    specs_out.zero_pad, specs_out.space_sign, specs_out.field_width,
                    specs_out.has_precision, specs_out.prec_value, specs_out.length_mod,
                    specs_out.conversion, specs_out.saturated};
            if (expected_specs.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected specifier transfer: %p", got);
            end else begin
                want = expected_specs.pop_front();
                if (got.left_align !== want.left_align || got.force_sign !== want.force_sign ||
                    got.alt_form !== want.alt_form || got.zero_pad !== want.zero_pad ||
                    got.space_sign !== want.space_sign ||
                    got.field_width !== want.field_width ||
                    got.has_precision !== want.has_precision ||
                    got.prec_value !== want.prec_value ||
                    got.length_mod !== want.length_mod ||
                    got.conversion !== want.conversion ||
                    got.saturated !== want.saturated) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("specifier mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial begin
        n_chars = 0;
        n_errors = 0;
        hold_cycles = 0;
        idle_on = 1'b1;
        clear_parse();
        i_rst_n <= 1'b0;
        chars_in.valid <= 1'b0;
        chars_in.ch <= '0;
        chars_in.start_req <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_flags_and_fields();
        test_special_cases();
        test_saturation();
        test_random_stream(450);
        test_output_hold();
        test_random_stream(750);
        idle_on = 1'b0;
        test_random_stream(880);

        wait_all_specs();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_format_spec_parser: PASS");
        else
            $display("tb_format_spec_parser: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_if.sv
hw/rtl/fsp_step.sv
hw/rtl/format_spec_parser.sv
hw/rtl/fsp_checker.sv
test/tb_format_spec_parser.sv
